// ===== hw/rtl/battery_cell_rc_model_step_top_assert.svh =====
// Assertion macros for the battery cell RC model step block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BATTERY_CELL_RC_MODEL_STEP_TOP_ASSERT_SVH
`define BATTERY_CELL_RC_MODEL_STEP_TOP_ASSERT_SVH
`ifndef SYNTH
`define BCRM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bcrm assertion failed");
`define BCRM_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bcrm reset assertion failed");
`else
`define BCRM_ASSERT(label, clk, rst, prop)
`define BCRM_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/bcrm_pkg.sv =====
// Shared types, constants and helpers for the battery cell RC model step block.
// Used by the microcode store, the datapath and the top level.
package bcrm_pkg;

  localparam logic [24:0] SOC_FULL = 25'd16777216;

  localparam logic [31:0] K_3_0 = 32'd50331648;
  localparam logic [31:0] K_1_2 = 32'd20132659;
  localparam logic [31:0] K_0_6 = 32'd10066330;
  localparam logic [31:0] K_0_3 = 32'd5033165;
  localparam logic [31:0] K_0_1 = 32'd1677722;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_COMMON = 4'd4;
  localparam upc_t UPC_LOAD   = 4'd13;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_CUR_SOCC,
    MUL_RC_DECAY,
    MUL_CUR_CHG,
    MUL_S_S,
    MUL_K12_S,
    MUL_S2_S,
    MUL_K06_S,
    MUL_K03_S2,
    MUL_K01_S3,
    MUL_CUR_R0
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_SOC,
    WB_RC_DECAY,
    WB_RC_CHARGE,
    WB_S2,
    WB_OCV_LIN,
    WB_S3,
    WB_SLOPE_LIN,
    WB_SQ_TERMS,
    WB_CUBE,
    WB_DROP,
    WB_LOAD
  } wb_op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_IF_LOAD
  } jmp_t;

  typedef enum logic [2:0] {
    REG_SOC_COEFF,
    REG_DECAY_COEFF,
    REG_CHARGE_COEFF,
    REG_SERIES_RES,
    REG_INIT_SOC,
    REG_INIT_RC
  } reg_idx_t;

  typedef struct packed {
    mul_op_t mul;
    wb_op_t  wb;
    jmp_t    jmp;
    upc_t    target;
    logic    last;
  } ucode_t;

  localparam ucode_t UC_IDLE = '{mul: MUL_NONE, wb: WB_NONE, jmp: JMP_NONE,
                                 target: 4'd0, last: 1'b0};

  typedef struct packed {
    logic        [31:0] soc_coeff;
    logic        [31:0] decay_coeff;
    logic        [31:0] charge_coeff;
    logic        [31:0] series_res;
    logic        [24:0] init_soc;
    logic signed [31:0] init_rc;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] terminal_voltage;
    logic        [24:0] soc_out;
    logic signed [31:0] rc_voltage_out;
    logic        [31:0] ocv_slope;
    logic               soc_clamped;
  } result_t;

  function automatic ucode_t mk_uword(input mul_op_t m, input wb_op_t w, input jmp_t j,
                                      input upc_t t, input logic l);
    ucode_t u;
    u.mul    = m;
    u.wb     = w;
    u.jmp    = j;
    u.target = t;
    u.last   = l;
    return u;
  endfunction

  function automatic logic signed [31:0] sat_q16(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/battery_cell_rc_model_step_top.sv =====
// Top level of the battery cell RC model step block: stream ports, configuration
// registers and microcode sequencer. Depends on bcrm_pkg, bcrm_ucode_rom and bcrm_datapath.
//
// Usage. Each word on the slave stream is one time step: tdata carries the cell
// current, tuser selects a normal step (0) or a load of the state from the
// initial registers (1). Each accepted word gives exactly one word on the master
// stream with the terminal voltage, state of charge, RC voltage, OCV slope and
// the clamp flag. The configuration port writes one register per cycle; the user
// must write it only while no step is in flight. The block does not enforce this.
// Timing. The time from acceptance to the result register is set by the program
// length of the sequencer, which is shorter for a load word than for a step. The
// sequencer feeds one shared 33 by 33 bit multiplier one product per cycle. A new
// word is accepted once the sequencer has handed its result to the output
// register, so a waiting result does not hold the input side back; a word is
// not taken while the one before it is still in the sequencer.
// Reset clears the sequencer and the output valid, sets the state of charge to
// full and the RC voltage to zero. If the receiver stalls, the sequencer holds
// on its last step until the output register is free.
module battery_cell_rc_model_step_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] current
  input  logic         s_tuser,   // [0] cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [31:0] terminal_voltage, [56:32] soc_out,
                                  // [88:57] rc_voltage_out, [120:89] ocv_slope,
                                  // [121] soc_clamped, [127:122] zero
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  `include "battery_cell_rc_model_step_top_assert.svh"

  bcrm_pkg::cfg_t    cfg;
  bcrm_pkg::upc_t    upc;
  bcrm_pkg::upc_t    upc_next;
  bcrm_pkg::ucode_t  uc;
  bcrm_pkg::ucode_t  uc_dp;
  bcrm_pkg::result_t res;
  logic              busy;
  logic              cmd_load;
  logic              accept;
  logic              out_free;
  logic              finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.soc_coeff    <= '0;
      cfg.decay_coeff  <= '0;
      cfg.charge_coeff <= '0;
      cfg.series_res   <= '0;
      cfg.init_soc     <= bcrm_pkg::SOC_FULL;
      cfg.init_rc      <= '0;
    end else if (cfg_we) begin
      case (bcrm_pkg::reg_idx_t'(cfg_addr))
        bcrm_pkg::REG_SOC_COEFF:    cfg.soc_coeff    <= cfg_data;
        bcrm_pkg::REG_DECAY_COEFF:  cfg.decay_coeff  <= cfg_data;
        bcrm_pkg::REG_CHARGE_COEFF: cfg.charge_coeff <= cfg_data;
        bcrm_pkg::REG_SERIES_RES:   cfg.series_res   <= cfg_data;
        bcrm_pkg::REG_INIT_SOC:     cfg.init_soc     <= cfg_data[24:0];
        bcrm_pkg::REG_INIT_RC:      cfg.init_rc      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bcrm_ucode_rom u_rom (
    .addr (upc),
    .uc   (uc)
  );

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = busy && uc.last && out_free;
  assign uc_dp    = busy ? uc : bcrm_pkg::UC_IDLE;

  always_comb begin
    case (uc.jmp)
      bcrm_pkg::JMP_ALWAYS:  upc_next = uc.target;
      bcrm_pkg::JMP_IF_LOAD: upc_next = cmd_load ? uc.target : bcrm_pkg::upc_t'(upc + 4'd1);
      default:               upc_next = bcrm_pkg::upc_t'(upc + 4'd1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      upc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        upc  <= '0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (busy && !uc.last) begin
        upc <= upc_next;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_load <= s_tuser;
    end
    if (finish) begin
      m_tdata <= {6'd0, res.soc_clamped, res.ocv_slope, res.rc_voltage_out,
                  res.soc_out, res.terminal_voltage};
    end
  end

  bcrm_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .cur_in (s_tdata),
    .cfg    (cfg),
    .uc     (uc_dp),
    .res    (res)
  );

  `BCRM_ASSERT(a_accept_starts_program, clk, rst, (s_tvalid && s_tready) |=> (busy && upc == '0))
  `BCRM_ASSERT(a_result_from_last_step, clk, rst, $rose(m_tvalid) |-> $past(busy && uc.last))
  `BCRM_ASSERT(a_soc_in_range, clk, rst, m_tvalid |-> (m_tdata[56:32] <= bcrm_pkg::SOC_FULL))
  `BCRM_ASSERT_RST(a_reset_idles, clk, rst |=> (!busy && !m_tvalid))

endmodule

// ===== hw/rtl/bcrm_ucode_rom.sv =====
// Microcode store of the battery cell RC model step sequencer.
// Depends on bcrm_pkg for the control word layout.
module bcrm_ucode_rom (
  input  bcrm_pkg::upc_t   addr,
  output bcrm_pkg::ucode_t uc
);

  always_comb begin
    case (addr)
      4'd0:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_CUR_SOCC, bcrm_pkg::WB_NONE,
                                     bcrm_pkg::JMP_IF_LOAD, bcrm_pkg::UPC_LOAD, 1'b0);
      4'd1:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_RC_DECAY, bcrm_pkg::WB_SOC,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd2:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_CUR_CHG, bcrm_pkg::WB_RC_DECAY,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd3:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_NONE, bcrm_pkg::WB_RC_CHARGE,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd4:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_S_S, bcrm_pkg::WB_NONE,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd5:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_K12_S, bcrm_pkg::WB_S2,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd6:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_S2_S, bcrm_pkg::WB_OCV_LIN,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd7:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_K06_S, bcrm_pkg::WB_S3,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd8:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_K03_S2, bcrm_pkg::WB_SLOPE_LIN,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd9:  uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_K01_S3, bcrm_pkg::WB_SQ_TERMS,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd10: uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_CUR_R0, bcrm_pkg::WB_CUBE,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd11: uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_NONE, bcrm_pkg::WB_DROP,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b0);
      4'd12: uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_NONE, bcrm_pkg::WB_NONE,
                                     bcrm_pkg::JMP_NONE, 4'd0, 1'b1);
      4'd13: uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_NONE, bcrm_pkg::WB_LOAD,
                                     bcrm_pkg::JMP_ALWAYS, bcrm_pkg::UPC_COMMON, 1'b0);
      default: uc = bcrm_pkg::mk_uword(bcrm_pkg::MUL_NONE, bcrm_pkg::WB_NONE,
                                       bcrm_pkg::JMP_NONE, 4'd0, 1'b1);
    endcase
  end

endmodule

// ===== hw/rtl/bcrm_datapath.sv =====
// Datapath of the battery cell RC model step block: shared multiplier, rounding and state.
// Driven by control words from bcrm_ucode_rom; depends on bcrm_pkg.
module bcrm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  cur_in,
  input  bcrm_pkg::cfg_t      cfg,
  input  bcrm_pkg::ucode_t    uc,
  output bcrm_pkg::result_t   res
);

  logic signed [31:0] cur;
  logic signed [65:0] prod;
  logic        [24:0] soc_level;
  logic signed [31:0] rc_voltage;
  logic signed [43:0] rc_acc;
  logic        [24:0] s2;
  logic        [24:0] s3;
  logic signed [31:0] ocv;
  logic signed [31:0] slope;
  logic signed [51:0] term_acc;
  logic               clamped;

  logic signed [32:0] op_a;
  logic signed [32:0] op_b;
  logic signed [65:0] rnd16_full;
  logic signed [65:0] rnd24_full;
  logic signed [49:0] r16;
  logic signed [41:0] r24;
  logic signed [50:0] soc_diff;
  logic signed [43:0] rc_dec;
  logic signed [43:0] rc_sum;
  logic signed [51:0] term_next;
  logic signed [51:0] term_rnd;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (uc.mul)
      bcrm_pkg::MUL_CUR_SOCC: begin
        op_a = {cur[31], cur};
        op_b = {1'b0, cfg.soc_coeff};
      end
      bcrm_pkg::MUL_RC_DECAY: begin
        op_a = {rc_voltage[31], rc_voltage};
        op_b = {1'b0, cfg.decay_coeff};
      end
      bcrm_pkg::MUL_CUR_CHG: begin
        op_a = {cur[31], cur};
        op_b = {1'b0, cfg.charge_coeff};
      end
      bcrm_pkg::MUL_S_S: begin
        op_a = {8'd0, soc_level};
        op_b = {8'd0, soc_level};
      end
      bcrm_pkg::MUL_K12_S: begin
        op_a = {1'b0, bcrm_pkg::K_1_2};
        op_b = {8'd0, soc_level};
      end
      bcrm_pkg::MUL_S2_S: begin
        op_a = {8'd0, s2};
        op_b = {8'd0, soc_level};
      end
      bcrm_pkg::MUL_K06_S: begin
        op_a = {1'b0, bcrm_pkg::K_0_6};
        op_b = {8'd0, soc_level};
      end
      bcrm_pkg::MUL_K03_S2: begin
        op_a = {1'b0, bcrm_pkg::K_0_3};
        op_b = {8'd0, s2};
      end
      bcrm_pkg::MUL_K01_S3: begin
        op_a = {1'b0, bcrm_pkg::K_0_1};
        op_b = {8'd0, s3};
      end
      bcrm_pkg::MUL_CUR_R0: begin
        op_a = {cur[31], cur};
        op_b = {1'b0, cfg.series_res};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Round half up: add half an LSB, then an arithmetic shift floors.
  assign rnd16_full = (prod + 66'sd32768) >>> 16;
  assign rnd24_full = (prod + 66'sd8388608) >>> 24;
  assign r16 = rnd16_full[49:0];
  assign r24 = rnd24_full[41:0];

  assign soc_diff  = $signed({26'd0, soc_level}) - $signed({r16[49], r16});
  assign rc_dec    = $signed({{12{rc_voltage[31]}}, rc_voltage}) - $signed({{2{r24[41]}}, r24});
  assign rc_sum    = rc_acc + $signed({{2{r24[41]}}, r24});
  assign term_next = $signed({{20{ocv[31]}}, ocv}) - $signed({{2{r16[49]}}, r16})
                     - $signed({{12{rc_voltage[31]}}, rc_voltage, 8'd0});
  assign term_rnd  = (term_acc + 52'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      soc_level  <= bcrm_pkg::SOC_FULL;
      rc_voltage <= '0;
      clamped    <= 1'b0;
    end else if (start) begin
      clamped <= 1'b0;
    end else begin
      case (uc.wb)
        bcrm_pkg::WB_SOC: begin
          if (soc_diff[50]) begin
            soc_level <= '0;
            clamped   <= 1'b1;
          end else if (soc_diff > $signed({26'd0, bcrm_pkg::SOC_FULL})) begin
            soc_level <= bcrm_pkg::SOC_FULL;
            clamped   <= 1'b1;
          end else begin
            soc_level <= soc_diff[24:0];
          end
        end
        bcrm_pkg::WB_RC_CHARGE: rc_voltage <= bcrm_pkg::sat_q16(rc_sum);
        bcrm_pkg::WB_LOAD: begin
          rc_voltage <= cfg.init_rc;
          if (cfg.init_soc > bcrm_pkg::SOC_FULL) begin
            soc_level <= bcrm_pkg::SOC_FULL;
            clamped   <= 1'b1;
          end else begin
            soc_level <= cfg.init_soc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= cur_in;
    end
    case (uc.wb)
      bcrm_pkg::WB_RC_DECAY:  rc_acc <= rc_dec;
      bcrm_pkg::WB_S2:        s2     <= r24[24:0];
      bcrm_pkg::WB_S3:        s3     <= r24[24:0];
      bcrm_pkg::WB_OCV_LIN:   ocv    <= $signed(bcrm_pkg::K_3_0) + $signed(r24[31:0]);
      bcrm_pkg::WB_SLOPE_LIN: slope  <= $signed(bcrm_pkg::K_1_2) - $signed(r24[31:0]);
      bcrm_pkg::WB_SQ_TERMS: begin
        ocv   <= ocv - $signed(r24[31:0]);
        slope <= slope + $signed(r24[31:0]);
      end
      bcrm_pkg::WB_CUBE:      ocv      <= ocv + $signed(r24[31:0]);
      bcrm_pkg::WB_DROP:      term_acc <= term_next;
      default: begin
      end
    endcase
  end

  always_comb begin
    res.terminal_voltage = bcrm_pkg::sat_q16(term_rnd[43:0]);
    res.soc_out          = soc_level;
    res.rc_voltage_out   = rc_voltage;
    res.ocv_slope        = slope;
    res.soc_clamped      = clamped;
  end

endmodule

// ===== verif/battery_cell_rc_model_step_top_tb.sv =====
// Self-checking testbench for battery_cell_rc_model_step_top: directed and random current and
// load words go in and every result word is compared with a fixed-point model of the cell in a scoreboard.
// Depends on bcrm_pkg and the RTL of the block only.
module battery_cell_rc_model_step_top_tb;

  localparam int     CYCLE_LIMIT = 400000;
  localparam int     HOLD_CYCLES = 400;
  localparam longint Q24_ONE     = longint'(bcrm_pkg::SOC_FULL);

  class cell_model_scoreboard;
    logic [31:0]        soc_coeff;
    logic [31:0]        decay_coeff;
    logic [31:0]        charge_coeff;
    logic [31:0]        series_res;
    logic [24:0]        init_soc;
    logic [31:0]        init_rc;
    longint             soc_level;
    longint             rc_voltage;
    bcrm_pkg::result_t  pending_results[$];
    int                 errors;

    function new();
      soc_coeff    = '0;
      decay_coeff  = '0;
      charge_coeff = '0;
      series_res   = '0;
      init_soc     = bcrm_pkg::SOC_FULL;
      init_rc      = '0;
      soc_level    = Q24_ONE;
      rc_voltage   = 0;
      errors       = 0;
    endfunction

    function void set_reg(bcrm_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        bcrm_pkg::REG_SOC_COEFF:    soc_coeff = value;
        bcrm_pkg::REG_DECAY_COEFF:  decay_coeff = value;
        bcrm_pkg::REG_CHARGE_COEFF: charge_coeff = value;
        bcrm_pkg::REG_SERIES_RES:   series_res = value;
        bcrm_pkg::REG_INIT_SOC:     init_soc = value[24:0];
        bcrm_pkg::REG_INIT_RC:      init_rc = value;
        default: ;
      endcase
    endfunction

    // Round half up while dropping the low bits; an arithmetic shift floors negatives.
    function longint round_shift(longint x, int bits);
      return (x + (longint'(1) <<< (bits - 1))) >>> bits;
    endfunction

    function longint sat_q16(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void predict_step(logic cmd, logic [31:0] current_word);
      longint            cur;
      longint            s;
      longint            s2;
      longint            s3;
      longint            ocv;
      longint            slope;
      longint            drop;
      longint            decay;
      longint            charge;
      bit                clamped;
      bcrm_pkg::result_t want;
      cur     = longint'($signed(current_word));
      clamped = 1'b0;
      if (cmd) begin
        s = longint'(init_soc);
        if (s > Q24_ONE) begin
          s       = Q24_ONE;
          clamped = 1'b1;
        end
        soc_level  = s;
        rc_voltage = longint'($signed(init_rc));
      end else begin
        s      = soc_level - round_shift(cur * longint'(soc_coeff), 16);
        decay  = round_shift(rc_voltage * longint'(decay_coeff), 24);
        charge = round_shift(cur * longint'(charge_coeff), 24);
        if (s < 0) begin
          s       = 0;
          clamped = 1'b1;
        end else if (s > Q24_ONE) begin
          s       = Q24_ONE;
          clamped = 1'b1;
        end
        soc_level  = s;
        rc_voltage = sat_q16(rc_voltage - decay + charge);
      end
      s     = soc_level;
      s2    = round_shift(s * s, 24);
      s3    = round_shift(s2 * s, 24);
      ocv   = longint'(bcrm_pkg::K_3_0) + round_shift(longint'(bcrm_pkg::K_1_2) * s, 24)
              - round_shift(longint'(bcrm_pkg::K_0_3) * s2, 24)
              + round_shift(longint'(bcrm_pkg::K_0_1) * s3, 24);
      slope = longint'(bcrm_pkg::K_1_2) - round_shift(longint'(bcrm_pkg::K_0_6) * s, 24)
              + round_shift(longint'(bcrm_pkg::K_0_3) * s2, 24);
      drop  = round_shift(cur * longint'(series_res), 16);
      want.terminal_voltage = 32'(sat_q16(round_shift(ocv - drop - rc_voltage * 256, 8)));
      want.soc_out          = s[24:0];
      want.rc_voltage_out   = rc_voltage[31:0];
      want.ocv_slope        = slope[31:0];
      want.soc_clamped      = clamped;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h got %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [127:0] word);
      bcrm_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, got %h", $time, word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("terminal_voltage", want.terminal_voltage, word[31:0]);
      compare_field("soc_out", {7'd0, want.soc_out}, {7'd0, word[56:32]});
      compare_field("rc_voltage_out", want.rc_voltage_out, word[88:57]);
      compare_field("ocv_slope", want.ocv_slope, word[120:89]);
      compare_field("soc_clamped", {31'd0, want.soc_clamped}, {31'd0, word[121]});
      compare_field("padding", 32'd0, {26'd0, word[127:122]});
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;   // [31:0] current
  logic         s_tuser;   // [0] cmd
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // [31:0] terminal_voltage, [56:32] soc_out, [88:57] rc_voltage_out,
                           // [120:89] ocv_slope, [121] soc_clamped, [127:122] zero
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_data;

  cell_model_scoreboard sb;
  bit                   gaps_on;
  bit                   hold_start;
  bit                   hold_done;
  int                   hold_left;
  int                   cycles;

  battery_cell_rc_model_step_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = !(gaps_on && $urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic send_word(input logic cmd, input logic [31:0] current_word);
    while (gaps_on && $urandom_range(99) < 27) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = current_word;
    do @(posedge clk); while (!s_tready);
    sb.predict_step(cmd, current_word);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input bcrm_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    sb.set_reg(idx, value);
  endtask

  function automatic logic [31:0] pick_coeff(input int unsigned typical);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(typical);
    endcase
  endfunction

  function automatic logic [31:0] pick_current();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  initial begin
    int p;
    int i;
    sb         = new();
    gaps_on    = 1'b1;
    hold_start = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset state and all-zero coefficients.
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b0, 32'h7fff_ffff);
    send_word(1'b1, 32'h8000_0000);

    // Largest soc, charge and series coefficients, no decay: clamps at both ends, RC saturation, load above full.
    wait_idle();
    write_reg(bcrm_pkg::REG_SOC_COEFF, 32'hffff_ffff);
    write_reg(bcrm_pkg::REG_DECAY_COEFF, 32'h0000_0000);
    write_reg(bcrm_pkg::REG_CHARGE_COEFF, 32'hffff_ffff);
    write_reg(bcrm_pkg::REG_SERIES_RES, 32'hffff_ffff);
    write_reg(bcrm_pkg::REG_INIT_SOC, 32'h01ff_ffff);
    write_reg(bcrm_pkg::REG_INIT_RC, 32'h7fff_ffff);
    send_word(1'b1, 32'h0000_0001);
    send_word(1'b0, 32'h7fff_ffff);
    send_word(1'b0, 32'h8000_0000);
    send_word(1'b0, 32'h0000_0000);

    // Unit soc coefficient: exact empty and exact full are reached without a clamp.
    wait_idle();
    write_reg(bcrm_pkg::REG_SOC_COEFF, 32'h0100_0000);
    write_reg(bcrm_pkg::REG_DECAY_COEFF, 32'hffff_ffff);
    write_reg(bcrm_pkg::REG_CHARGE_COEFF, 32'h0000_0000);
    write_reg(bcrm_pkg::REG_SERIES_RES, 32'h0000_0000);
    write_reg(bcrm_pkg::REG_INIT_SOC, 32'h0000_0000);
    write_reg(bcrm_pkg::REG_INIT_RC, 32'h8000_0000);
    send_word(1'b1, 32'h0000_0000);
    send_word(1'b0, 32'hffff_0000);
    send_word(1'b0, 32'h0001_0000);
    send_word(1'b0, 32'h0001_0001);
    send_word(1'b0, 32'hffff_ffff);

    wait_idle();
    write_reg(bcrm_pkg::REG_INIT_SOC, 32'(bcrm_pkg::SOC_FULL));
    send_word(1'b1, 32'h0001_0000);
    wait_idle();
    write_reg(bcrm_pkg::REG_INIT_SOC, 32'(bcrm_pkg::SOC_FULL) + 32'd1);
    send_word(1'b1, 32'hffff_ffff);

    for (p = 0; p < 12; p++) begin
      wait_idle();
      write_reg(bcrm_pkg::REG_SOC_COEFF, pick_coeff(32'h0004_0000));
      write_reg(bcrm_pkg::REG_DECAY_COEFF, pick_coeff(32'h0040_0000));
      write_reg(bcrm_pkg::REG_CHARGE_COEFF, pick_coeff(32'h0010_0000));
      write_reg(bcrm_pkg::REG_SERIES_RES, pick_coeff(32'h0040_0000));
      write_reg(bcrm_pkg::REG_INIT_SOC,
                ($urandom_range(3) == 0) ? $urandom_range(32'h01ff_ffff)
                                         : $urandom_range(32'(bcrm_pkg::SOC_FULL)));
      write_reg(bcrm_pkg::REG_INIT_RC,
                ($urandom_range(3) == 0) ? $urandom
                                         : $urandom_range(32'h0008_0000) - 32'h0004_0000);
      gaps_on = (p != 3);
      for (i = 0; i < 157; i++) begin
        if (p == 5 && i == 20) hold_start = 1'b1;
        if (p == 8 && i == 80) wait_idle();
        send_word($urandom_range(11) == 0, pick_current());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bcrm_pkg.sv
hw/rtl/bcrm_ucode_rom.sv
hw/rtl/bcrm_datapath.sv
hw/rtl/battery_cell_rc_model_step_top.sv
verif/battery_cell_rc_model_step_top_tb.sv
